/* hdl/cad_pkg.sv */
// ----------------------------------------------------------------------------
// cad_pkg
// Shared codes and types for the circular array deque unit.
// ----------------------------------------------------------------------------
package cad_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;

  localparam logic [2:0] REQ_INS_BACK  = 3'd0;
  localparam logic [2:0] REQ_INS_FRONT = 3'd1;
  localparam logic [2:0] REQ_REM_FRONT = 3'd2;
  localparam logic [2:0] REQ_REM_BACK  = 3'd3;
  localparam logic [2:0] REQ_LIST      = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_OVERFLOW    = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW   = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOWED = 3'd3;
  localparam logic [2:0] ST_EMPTY       = 3'd4;

  localparam logic [1:0] MODE_IN_RESTR  = 2'd1;
  localparam logic [1:0] MODE_OUT_RESTR = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_cmd_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] status;
    logic       last;
    logic       from_ram;
  } res_t;

endpackage

/* hdl/circular_array_deque_unit.sv */
// ----------------------------------------------------------------------------
// circular_array_deque_unit
// Double-ended queue in a circular single-port-read / single-port-write RAM.
//
// Requests: start with req_type and item_value, taken when busy is low.
// Codes: insert back, insert front, remove front, remove back, list.
// Config: cfg_wr_en / cfg_wr_data set the restriction mode (input or
// output restricted); write it only while the unit is idle.
// Results: result_valid strobes one beat per cycle with status, out_value
// and last_result; the receiver cannot stall, results must be taken.
// Latency: the first result of a request appears the cycle after accept.
// Throughput: inserts, removes and error cases can be issued back to back.
// A listing of N elements gives N beats on consecutive cycles and holds
// busy high until its last element is read, one RAM read a cycle. A
// remove reads its value from the RAM in the accept cycle.
// Reset: rst (synchronous) empties the queue and clears the mode; RAM
// contents are not cleared and only occupied slots are ever read.
// ----------------------------------------------------------------------------
module circular_array_deque_unit import cad_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       req_type,
  input  logic [VAL_W-1:0] item_value,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  output logic             result_valid,
  output logic [2:0]       status,
  output logic [VAL_W-1:0] out_value,
  output logic             last_result
);

  localparam int IW = $clog2(DEPTH);

  ram_cmd_t         ram_cmd;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    rd_addr;
  res_t             res;
  logic [VAL_W-1:0] slot_store [DEPTH];
  logic [VAL_W-1:0] rd_data;

  cad_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_cmd     (ram_cmd),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (ram_cmd.wr_en) begin
      slot_store[wr_addr] <= item_value;
    end
    if (ram_cmd.rd_en) begin
      rd_data <= slot_store[rd_addr];
    end
  end

  assign result_valid = res.valid;
  assign status       = res.status;
  assign last_result  = res.last;
  assign out_value    = res.from_ram ? rd_data : '0;

endmodule

/* hdl/cad_ctrl.sv */
// ----------------------------------------------------------------------------
// cad_ctrl
// Request decode, front/back index tracking, mode register and list sequencer.
// ----------------------------------------------------------------------------
module cad_ctrl import cad_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       req_type,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  output ram_cmd_t         ram_cmd,
  output logic [IW-1:0]    wr_addr,
  output logic [IW-1:0]    rd_addr,
  output res_t             res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic          state, state_next;
  logic [IW-1:0] front, front_next;
  logic [IW-1:0] back, back_next;
  logic          empty, empty_next;
  logic [IW-1:0] pos, pos_next;
  logic [IW-1:0] cnt, cnt_next;
  logic [1:0]    mode;
  res_t          res_next;
  logic          accept;
  logic          full;
  logic          list_last;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] i);
    return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign busy   = (state == S_LIST);
  assign accept = start && !busy;
  assign full   = !empty && (wrap_inc(back) == front);

  always_comb begin
    state_next = state;
    front_next = front;
    back_next  = back;
    empty_next = empty;
    pos_next   = pos;
    cnt_next   = cnt;
    res_next   = '0;
    ram_cmd    = '0;
    wr_addr    = '0;
    rd_addr    = pos;
    list_last  = (pos == back) || (cnt == IW'(DEPTH - 1));
    if (state == S_LIST) begin
      ram_cmd.rd_en     = 1'b1;
      res_next.valid    = 1'b1;
      res_next.status   = ST_OK;
      res_next.last     = list_last;
      res_next.from_ram = 1'b1;
      pos_next          = wrap_inc(pos);
      cnt_next          = cnt + 1'b1;
      if (list_last) begin
        state_next = S_IDLE;
      end
    end else if (accept) begin
      res_next.valid = 1'b1;
      res_next.last  = 1'b1;
      case (req_type)
        REQ_INS_BACK, REQ_INS_FRONT: begin
          if (req_type == REQ_INS_FRONT && mode == MODE_IN_RESTR) begin
            res_next.status = ST_NOT_ALLOWED;
          end else if (full) begin
            res_next.status = ST_OVERFLOW;
          end else begin
            res_next.status = ST_OK;
            ram_cmd.wr_en   = 1'b1;
            if (empty) begin
              wr_addr    = '0;
              front_next = '0;
              back_next  = '0;
              empty_next = 1'b0;
            end else if (req_type == REQ_INS_BACK) begin
              wr_addr   = wrap_inc(back);
              back_next = wrap_inc(back);
            end else begin
              wr_addr    = wrap_dec(front);
              front_next = wrap_dec(front);
            end
          end
        end
        REQ_REM_FRONT, REQ_REM_BACK: begin
          if (req_type == REQ_REM_BACK && mode == MODE_OUT_RESTR) begin
            res_next.status = ST_NOT_ALLOWED;
          end else if (empty) begin
            res_next.status = ST_UNDERFLOW;
          end else begin
            res_next.status   = ST_OK;
            res_next.from_ram = 1'b1;
            ram_cmd.rd_en     = 1'b1;
            rd_addr           = (req_type == REQ_REM_FRONT) ? front : back;
            if (front == back) begin
              empty_next = 1'b1;
              front_next = '0;
              back_next  = '0;
            end else if (req_type == REQ_REM_FRONT) begin
              front_next = wrap_inc(front);
            end else begin
              back_next = wrap_dec(back);
            end
          end
        end
        REQ_LIST: begin
          if (empty) begin
            res_next.status = ST_EMPTY;
          end else begin
            res_next.status   = ST_OK;
            res_next.from_ram = 1'b1;
            ram_cmd.rd_en     = 1'b1;
            rd_addr           = front;
            res_next.last     = (front == back);
            pos_next          = wrap_inc(front);
            cnt_next          = IW'(1);
            if (front != back) begin
              state_next = S_LIST;
            end
          end
        end
        default: begin
          res_next.status = ST_NOT_ALLOWED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      back  <= '0;
      empty <= 1'b1;
      mode  <= '0;
      res   <= '0;
      pos   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      back  <= back_next;
      empty <= empty_next;
      res   <= res_next;
      pos   <= pos_next;
      cnt   <= cnt_next;
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_array_deque_unit. A clocked driver feeds
// requests from a queue and a clocked monitor compares every result beat
// with a shadow deque. Runs directed corner requests, then fill and drain
// bursts under every restriction mode with varying sender idle rates.
// ----------------------------------------------------------------------------
module tb;
  import cad_pkg::*;

  localparam logic [1:0] MODE_FREE  = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         NSLOT      = DEPTH_DEF;

  typedef struct {
    logic [2:0]       kind;
    logic [VAL_W-1:0] val;
  } deque_req_t;

  typedef struct {
    logic [2:0]       status;
    logic [VAL_W-1:0] val;
    logic             last;
  } deque_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       req_type = REQ_INS_BACK;
  logic [VAL_W-1:0] item_value = '0;
  logic             cfg_wr_en = 1'b0;
  logic [1:0]       cfg_wr_data = MODE_FREE;
  logic             result_valid;
  logic [2:0]       status;
  logic [VAL_W-1:0] out_value;
  logic             last_result;

  deque_req_t  req_fifo[$];
  deque_beat_t beats_due[$];
  int          idle_pct = 0;
  int          errors = 0;

  logic [VAL_W-1:0] shadow_slots[NSLOT];
  logic [3:0]       shadow_front = '0;
  logic [3:0]       shadow_back = '0;
  logic             shadow_empty = 1'b1;
  logic [1:0]       shadow_mode = MODE_FREE;

  circular_array_deque_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .item_value  (item_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result_valid(result_valid),
    .status      (status),
    .out_value   (out_value),
    .last_result (last_result)
  );

  always #6 clk = ~clk;

  function automatic void push_beat(logic [2:0] st, logic [VAL_W-1:0] v, logic lst);
    deque_beat_t b;
    b.status = st;
    b.val    = v;
    b.last   = lst;
    beats_due.push_back(b);
  endfunction

  // Shadow deque: applies one request and queues the beats it must produce.
  function automatic void apply_request(logic [2:0] kind, logic [VAL_W-1:0] v);
    logic [3:0]       pos;
    logic [VAL_W-1:0] got;
    logic             full;
    full = !shadow_empty && (shadow_back + 4'd1 == shadow_front);
    case (kind)
      REQ_INS_BACK, REQ_INS_FRONT: begin
        if (kind == REQ_INS_FRONT && shadow_mode == MODE_IN_RESTR) begin
          push_beat(ST_NOT_ALLOWED, '0, 1'b1);
        end else if (full) begin
          push_beat(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (shadow_empty) begin
            shadow_front = '0;
            shadow_back  = '0;
            shadow_empty = 1'b0;
            shadow_slots[0] = v;
          end else if (kind == REQ_INS_BACK) begin
            shadow_back = shadow_back + 4'd1;
            shadow_slots[shadow_back] = v;
          end else begin
            shadow_front = shadow_front - 4'd1;
            shadow_slots[shadow_front] = v;
          end
          push_beat(ST_OK, '0, 1'b1);
        end
      end
      REQ_REM_FRONT, REQ_REM_BACK: begin
        if (kind == REQ_REM_BACK && shadow_mode == MODE_OUT_RESTR) begin
          push_beat(ST_NOT_ALLOWED, '0, 1'b1);
        end else if (shadow_empty) begin
          push_beat(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          got = shadow_slots[kind == REQ_REM_FRONT ? shadow_front : shadow_back];
          if (shadow_front == shadow_back) begin
            shadow_empty = 1'b1;
            shadow_front = '0;
            shadow_back  = '0;
          end else if (kind == REQ_REM_FRONT) begin
            shadow_front = shadow_front + 4'd1;
          end else begin
            shadow_back = shadow_back - 4'd1;
          end
          push_beat(ST_OK, got, 1'b1);
        end
      end
      REQ_LIST: begin
        if (shadow_empty) begin
          push_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          pos = shadow_front;
          while (pos != shadow_back) begin
            push_beat(ST_OK, shadow_slots[pos], 1'b0);
            pos = pos + 4'd1;
          end
          push_beat(ST_OK, shadow_slots[pos], 1'b1);
        end
      end
      default: push_beat(ST_NOT_ALLOWED, '0, 1'b1);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_req(logic [2:0] kind, logic [VAL_W-1:0] v);
    deque_req_t r;
    r.kind = kind;
    r.val  = v;
    req_fifo.push_back(r);
  endfunction

  // Random request with a given share of inserts among inserts and removes.
  function automatic void queue_random(int ins_pct);
    int          roll;
    logic [2:0]  kind;
    roll = $urandom_range(99);
    if (roll < 3) begin
      kind = 3'($urandom_range(7, 5));
    end else if (roll < 11) begin
      kind = REQ_LIST;
    end else if ($urandom_range(99) < ins_pct) begin
      kind = $urandom_range(1) ? REQ_INS_FRONT : REQ_INS_BACK;
    end else begin
      kind = $urandom_range(1) ? REQ_REM_FRONT : REQ_REM_BACK;
    end
    queue_req(kind, pick_value());
  endfunction

  // Driver
  always @(posedge clk) begin
    deque_req_t nxt;
    logic       hold;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (cfg_wr_en) shadow_mode = cfg_wr_data;
      if (start && !busy) apply_request(req_type, item_value);
      hold = start && busy;
      if (!hold && req_fifo.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = req_fifo.pop_front();
        req_type   <= nxt.kind;
        item_value <= nxt.val;
        hold = 1'b1;
      end
      start <= hold;
    end
  end

  // Monitor
  always @(posedge clk) begin
    deque_beat_t want;
    if (!rst && result_valid) begin
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got status=%0d value=%h last=%b",
                 $time, status, out_value, last_result);
      end else begin
        want = beats_due.pop_front();
        if (status !== want.status || out_value !== want.val || last_result !== want.last) begin
          errors++;
          $display("%0t: mismatch expected status=%0d value=%h last=%b,",
                   $time, want.status, want.val, want.last);
          $display("%0t:          got status=%0d value=%h last=%b",
                   $time, status, out_value, last_result);
        end
      end
    end
  end

  // sampled at the falling edge so the driver's updates have settled
  task automatic drain_and_idle();
    while (req_fifo.size() != 0 || start || beats_due.size() != 0 || busy)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [1:0] phase_mode[5];
    int         phase_idle[5];
    phase_mode = '{MODE_FREE, MODE_OUT_RESTR, MODE_IN_RESTR, MODE_SPARE, MODE_FREE};
    phase_idle = '{0, 88, 0, 37, 88};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 5; p++) begin
      write_mode(phase_mode[p]);
      idle_pct = phase_idle[p];
      if (p == 0) begin
        queue_req(REQ_REM_BACK, 32'h1);
        queue_req(REQ_REM_FRONT, '1);
        queue_req(REQ_LIST, '0);
        queue_req(REQ_INS_BACK, 32'h8000_0000);
        queue_req(REQ_INS_BACK, 32'h7fff_ffff);
        queue_req(REQ_INS_FRONT, '1);
        queue_req(REQ_INS_FRONT, '0);
        queue_req(REQ_LIST, '0);
        queue_req(3'd5, '1);
        queue_req(3'd6, 32'h5555_5555);
        queue_req(3'd7, 32'haaaa_aaaa);
        queue_req(REQ_REM_FRONT, '0);
        queue_req(REQ_REM_BACK, '0);
        queue_req(REQ_LIST, '0);
        queue_req(REQ_REM_FRONT, '0);
        queue_req(REQ_REM_FRONT, '0);
        queue_req(REQ_REM_FRONT, '0);
        queue_req(REQ_INS_FRONT, 32'h1234_5678);
        queue_req(REQ_LIST, '0);
        queue_req(REQ_REM_BACK, '0);
        queue_req(REQ_REM_BACK, '0);
      end
      // fill burst then drain burst, reaching both full and empty
      for (int i = 0; i < 78; i++)
        queue_random(i < 39 ? 90 : 10);
      drain_and_idle();
    end
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* circular_array_deque_unit.f */
hdl/cad_pkg.sv
hdl/cad_ctrl.sv
hdl/circular_array_deque_unit.sv
tb/tb.sv
